// ===== hw/rtl/esd_pkg.sv =====
// Escape sequence decoder package: shared types and constants.
// Used by the output interface, all decoder modules and the checker.
package esd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  // escape_kind encodings; values above KIND_DONE count pending UTF-8 bytes
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_HEX  = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } esd_item_t;

  typedef struct packed {
    logic [CP_W-1:0] cp_value;
    logic            error;
  } esd_result_t;

endpackage

// ===== hw/rtl/esd_if.sv =====
// Valid/ready channel interfaces for the escape sequence decoder.
// Depends on esd_pkg for the code point width.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface esd_out_if;
  logic                     valid;
  logic                     ready;
  logic [esd_pkg::CP_W-1:0] cp_value;
  logic                     error;

  modport source (output valid, output cp_value, output error, input ready);
  modport sink   (input valid, input cp_value, input error, output ready);
endinterface

// ===== hw/rtl/esd_in_reg.sv =====
// Input register stage: captures one byte per transfer.
// Depends on esd_pkg and esd_in_if.
module esd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  esd_in_if.sink            in_ch,
  input  logic              take,
  output logic              item_valid,
  output esd_pkg::esd_item_t item
);
  import esd_pkg::*;

  logic      valid_r;
  esd_item_t item_r;

  assign in_ch.ready = !valid_r || take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.in_byte <= in_ch.in_byte;
      item_r.is_last <= in_ch.is_last;
    end
  end

endmodule

// ===== hw/rtl/esd_decode.sv =====
// Escape decode: per-sequence state and single-pass byte update.
// Depends on esd_pkg.
module esd_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  esd_pkg::esd_item_t   item,
  output esd_pkg::esd_result_t result
);
  import esd_pkg::*;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_UC_U   = 8'h55;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int unsigned SUM_W = CP_W + 4;

  logic [1:0]      pos_r, pos_nxt;
  logic [2:0]      kind_r, kind_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            ovf_r, ovf_nxt;
  logic            brc_r, brc_nxt;

  logic [7:0]       b;
  logic             is_oct;
  logic             hex_ok;
  logic [3:0]       hex_val;
  logic             dig_en;
  logic [3:0]       dig;
  logic [SUM_W-1:0] sum;
  logic [CP_W-1:0]  val;
  logic             err;

  always_comb begin
    b      = item.in_byte;
    is_oct = (b >= CH_0) && (b <= CH_7);
    hex_ok = 1'b1;
    hex_val = 4'd0;
    if ((b >= CH_0) && (b <= CH_9)) begin
      hex_val = b[3:0];
    end else if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
      hex_val = 4'(b[2:0] + 3'd1) + 4'd8;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    brc_nxt  = brc_r;
    dig_en   = 1'b0;
    dig      = 4'd0;
    sum      = '0;
    val      = '0;
    err      = 1'b0;

    if (pos_r == 2'd1) begin
      case (b)
        CH_LC_U, CH_UC_U, CH_LC_X: kind_nxt = KIND_HEX;
        CH_LC_A: begin acc_nxt = 21'h7; kind_nxt = KIND_DONE; end
        CH_LC_B: begin acc_nxt = 21'h8; kind_nxt = KIND_DONE; end
        CH_LC_T: begin acc_nxt = 21'h9; kind_nxt = KIND_DONE; end
        CH_LC_N: begin acc_nxt = 21'hA; kind_nxt = KIND_DONE; end
        CH_LC_V: begin acc_nxt = 21'hB; kind_nxt = KIND_DONE; end
        CH_LC_F: begin acc_nxt = 21'hC; kind_nxt = KIND_DONE; end
        CH_LC_R: begin acc_nxt = 21'hD; kind_nxt = KIND_DONE; end
        default: begin
          if (is_oct) begin
            acc_nxt  = CP_W'(b[2:0]);
            kind_nxt = KIND_OCT;
          end else if (!b[7]) begin
            acc_nxt  = CP_W'(b);
            kind_nxt = KIND_DONE;
          end else if (b < 8'hE0) begin
            acc_nxt  = CP_W'(b[4:0]);
            kind_nxt = KIND_DONE + 3'd1;
          end else if (b < 8'hF0) begin
            acc_nxt  = CP_W'(b[3:0]);
            kind_nxt = KIND_DONE + 3'd2;
          end else begin
            acc_nxt  = CP_W'(b[2:0]);
            kind_nxt = KIND_DONE + 3'd3;
          end
        end
      endcase
    end else if (pos_r[1]) begin
      if (kind_r == KIND_HEX) begin
        if (pos_r == 2'd2 && b == CH_LBRACE) begin
          brc_nxt = 1'b1;
          if (item.is_last) ovf_nxt = 1'b1;
        end else if (brc_r && item.is_last) begin
          if (b != CH_RBRACE) ovf_nxt = 1'b1;
        end else if (!hex_ok) begin
          ovf_nxt = 1'b1;
        end else begin
          dig_en = 1'b1;
          dig    = hex_val;
          sum    = {acc_r, 4'd0};
        end
      end else if (kind_r == KIND_OCT) begin
        if (is_oct) begin
          dig_en = 1'b1;
          dig    = {1'b0, b[2:0]};
          sum    = {1'b0, acc_r, 3'd0};
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (kind_r > KIND_DONE) begin
        acc_nxt  = {acc_r[CP_W-7:0], b[5:0]};
        kind_nxt = kind_r - 3'd1;
      end
    end

    if (dig_en && !ovf_r) begin
      sum = sum + SUM_W'(dig);
      if (sum > SUM_W'(CP_MAX)) begin
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = sum[CP_W-1:0];
      end
    end

    // pad missing UTF-8 continuation bytes with zeros
    case (kind_nxt)
      KIND_DONE + 3'd1: val = {acc_nxt[CP_W-7:0], 6'd0};
      KIND_DONE + 3'd2: val = {acc_nxt[CP_W-13:0], 12'd0};
      KIND_DONE + 3'd3: val = {acc_nxt[CP_W-19:0], 18'd0};
      default:          val = acc_nxt;
    endcase
    err = ovf_nxt || (pos_r == 2'd0) || (val > CP_MAX);

    if (item.is_last) begin
      pos_nxt  = 2'd0;
      kind_nxt = KIND_NONE;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;
      brc_nxt  = 1'b0;
    end else if (pos_r != 2'd3) begin
      pos_nxt = pos_r + 2'd1;
    end
  end

  assign result.cp_value = err ? '0 : val;
  assign result.error    = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      kind_r <= KIND_NONE;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      brc_r  <= 1'b0;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      brc_r  <= brc_nxt;
    end
  end

endmodule

// ===== hw/rtl/esd_out_reg.sv =====
// Result register: holds one decoded code point until transferred.
// Depends on esd_pkg and esd_out_if.
module esd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  esd_pkg::esd_result_t result,
  output logic                 space,
  esd_out_if.source            out_ch
);
  import esd_pkg::*;

  logic        valid_r;
  esd_result_t res_r;

  assign space           = !valid_r || out_ch.ready;
  assign out_ch.valid    = valid_r;
  assign out_ch.cp_value = res_r.cp_value;
  assign out_ch.error    = res_r.error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule

// ===== hw/rtl/escape_sequence_decoder.sv =====
// Escape sequence decoder top: input register, decode, result register.
// Accepts one byte per cycle; out valid rises once the last byte's result is registered.
// Throughput is one byte per cycle while the result side takes results when offered.
// rst_n is synchronous, active low; it clears both stage valids and the sequence state.
// Depends on esd_pkg, esd_if, esd_in_reg, esd_decode, esd_out_reg.
module escape_sequence_decoder (
  input  logic      clk,
  input  logic      rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);
  import esd_pkg::*;

  logic        item_valid;
  esd_item_t   item;
  esd_result_t result;
  logic        space;
  logic        advance;

  // a non-final byte never needs result space
  assign advance = item_valid && (!item.is_last || space);

  esd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  esd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  esd_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance && item.is_last),
    .result (result),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

// ===== hw/rtl/esd_checker.sv =====
// Port-level checks for the escape sequence decoder, bound to the top level.
// Depends on esd_pkg and escape_sequence_decoder.
module esd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [esd_pkg::CP_W-1:0] out_cp_value,
  input logic                     out_error
);
  import esd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cp_value) && $stable(out_error))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_cp_value == '0)
    else $error("error result carries nonzero code point");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cp_value <= CP_MAX)
    else $error("code point above range");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side ready");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_cp_value (out_ch.cp_value),
  .out_error    (out_ch.error)
);
